[hw/rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define CHK_IMPL(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define CHK_NEXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

[hw/rtl/hsfe_pkg.sv]
// Types and constants of the hexahedral shape function evaluator.
// No dependencies.
package hsfe_pkg;
   localparam int CW = 16;
   localparam int OW = 17;
   localparam int FRAC_BITS = 14;
   localparam logic KIND_HEX8 = 1'b0;
   localparam logic KIND_HEX20 = 1'b1;

   typedef struct packed {
      logic signed [CW-1:0] r;
      logic signed [CW-1:0] s;
      logic signed [CW-1:0] t;
      logic kind;
      logic derivs;
   } point_type;

   // per-axis node direction: 2'b01 +1, 2'b11 -1, 2'b00 quadratic
   typedef logic [1:0] dir_type;

   function automatic logic [5:0] node_dir(input logic [4:0] n);
      case (n)
         5'd0: node_dir = {2'b11, 2'b11, 2'b01};
         5'd1: node_dir = {2'b11, 2'b01, 2'b01};
         5'd2: node_dir = {2'b11, 2'b01, 2'b11};
         5'd3: node_dir = {2'b11, 2'b11, 2'b11};
         5'd4: node_dir = {2'b01, 2'b11, 2'b01};
         5'd5: node_dir = {2'b01, 2'b01, 2'b01};
         5'd6: node_dir = {2'b01, 2'b01, 2'b11};
         5'd7: node_dir = {2'b01, 2'b11, 2'b11};
         5'd8: node_dir = {2'b11, 2'b00, 2'b01};
         5'd9: node_dir = {2'b11, 2'b01, 2'b00};
         5'd10: node_dir = {2'b11, 2'b00, 2'b11};
         5'd11: node_dir = {2'b11, 2'b11, 2'b00};
         5'd12: node_dir = {2'b01, 2'b00, 2'b01};
         5'd13: node_dir = {2'b01, 2'b01, 2'b00};
         5'd14: node_dir = {2'b01, 2'b00, 2'b11};
         5'd15: node_dir = {2'b01, 2'b11, 2'b00};
         5'd16: node_dir = {2'b00, 2'b11, 2'b01};
         5'd17: node_dir = {2'b00, 2'b01, 2'b01};
         5'd18: node_dir = {2'b00, 2'b01, 2'b11};
         5'd19: node_dir = {2'b00, 2'b11, 2'b11};
         default: node_dir = 6'd0;
      endcase
   endfunction
endpackage

[hw/rtl/hsfe_mulq.sv]
// Rounded fixed-point multiplier, one multiply per cycle, registered result.
// Depends on nothing.
module hsfe_mulq #(
   parameter int AW = 24,
   parameter int FB = 14
) (
   input  logic                 clock,
   input  logic signed [AW-1:0] a,
   input  logic signed [AW-1:0] b,
   input  logic [1:0]           extra,
   output logic signed [AW-1:0] p
);
   logic [AW-1:0]   ua, ub;
   logic [2*AW-1:0] prod, rnd;
   logic [AW-1:0]   mag;
   logic            neg;
   logic signed [AW-1:0] p_in, p_ff;
   int unsigned     k;

   always_comb begin
      neg  = a[AW-1] ^ b[AW-1];
      ua   = a[AW-1] ? -a : a;
      ub   = b[AW-1] ? -b : b;
      prod = ua * ub;
      k    = FB + 32'(extra);
      rnd  = (prod + ((2*AW)'(1) << (k - 1))) >> k;
      mag  = rnd[AW-1:0];
      p_in = neg ? -$signed(mag) : $signed(mag);
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;
endmodule

[hw/rtl/hsfe_front.sv]
// Front end: accepts points and holds them in a two-entry queue.
// Depends on hsfe_pkg.
module hsfe_front import hsfe_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  point_type in_pt,
   output logic      q_valid,
   input  logic      q_pop,
   output point_type q_pt
);
   point_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push;

   assign in_ready = cnt_ff != 2'd2;
   assign push = in_valid && in_ready;
   assign q_valid = cnt_ff != 2'd0;
   assign q_pt = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_pt;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (q_pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(q_pop);
      end
   end
endmodule

[hw/rtl/hsfe_back.sv]
// Back end: sequences nodes through one shared rounded multiplier.
// Depends on hsfe_pkg and hsfe_mulq.
module hsfe_back import hsfe_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   output logic            q_pop,
   input  point_type       q_pt,
   output logic            o_valid,
   input  logic            o_ready,
   output logic [4:0]      o_node,
   output logic [4*OW-1:0] o_vals,
   output logic            o_last
);
   // operands stay below 2^19 in magnitude for any 16-bit coordinate
   localparam int AW = 24;
   typedef enum logic [2:0] {IDLE, PREP, LOAD, MUL, WAIT, OUT} st_type;
   typedef logic signed [AW-1:0] w_type;
   localparam w_type ONE  = w_type'(1) <<< FRAC_BITS;
   localparam w_type FIVE = w_type'(5) <<< FRAC_BITS;

   st_type st_ff;
   point_type pt_ff;
   logic [4:0] node_ff;
   logic [3:0] step_ff;
   w_type x_ff [3];
   w_type sq_ff [3];
   w_type f_ff [3];
   w_type sum_ff;
   w_type res_ff [4];
   logic [4*OW-1:0] vals_ff;
   logic [4:0] onode_ff;
   logic olast_ff, ovalid_ff;
   w_type ma, mb, mp;
   logic [1:0] mx;
   w_type fac [3];
   logic [5:0] dir;
   logic quad, last_node, last_step, out_load, cap;
   logic [1:0] q, bq, cq;
   logic [3:0] nsteps, rstep;

   hsfe_mulq #(.AW(AW), .FB(FRAC_BITS)) u_mul (
      .clock(clock), .a(ma), .b(mb), .extra(mx), .p(mp));

   function automatic logic [OW-1:0] sat(input w_type v);
      if (v > w_type'(65535)) sat = OW'(65535);
      else if (v < -w_type'(65536)) sat = OW'(-65536);
      else sat = v[OW-1:0];
   endfunction

   function automatic w_type sgn(input dir_type d, input w_type v);
      sgn = (d == 2'b11) ? -v : v;
   endfunction

   function automatic logic [1:0] ob(input logic [1:0] aa);
      ob = (aa == 2'd0) ? 2'd1 : 2'd0;
   endfunction
   function automatic logic [1:0] oc(input logic [1:0] aa);
      oc = (aa == 2'd2) ? 2'd1 : 2'd2;
   endfunction

   // node decode and axis factors (linear 1+-x or quadratic 1-x*x)
   always_comb begin
      dir  = node_dir(node_ff);
      quad = pt_ff.kind && node_ff >= 5'd8;
      q    = (dir[1:0] == 2'b00) ? 2'd0 : (dir[3:2] == 2'b00) ? 2'd1 : 2'd2;
      bq   = ob(q);
      cq   = oc(q);
      last_node = node_ff == ((pt_ff.kind == KIND_HEX20) ? 5'd19 : 5'd7);
      for (int i = 0; i < 3; i++) begin
         case (dir[2*i +: 2])
            2'b01: fac[i] = ONE + x_ff[i];
            2'b11: fac[i] = ONE - x_ff[i];
            default: fac[i] = ONE - sq_ff[i];
         endcase
      end
   end

   // step schedule of the shared multiplier; a result lands in the next cycle
   // and a dependent step takes it straight from the multiplier output
   always_comb begin
      ma = '0; mb = '0; mx = 2'd0;
      if (pt_ff.kind == KIND_HEX8) nsteps = 4'd5;
      else if (!quad) nsteps = 4'd9;
      else nsteps = 4'd6;
      if (st_ff == PREP) begin
         case (step_ff)
            4'd0: begin ma = x_ff[0]; mb = x_ff[0]; end
            4'd1: begin ma = x_ff[1]; mb = x_ff[1]; end
            4'd2: begin ma = x_ff[2]; mb = x_ff[2]; end
            default: ;
         endcase
      end else if (st_ff == MUL) begin
         if (pt_ff.kind == KIND_HEX8) begin
            case (step_ff)
               4'd0: begin ma = f_ff[0]; mb = f_ff[1]; end
               4'd1: begin ma = mp; mb = f_ff[2]; mx = 2'd3; end
               4'd2: begin ma = f_ff[1]; mb = f_ff[2]; mx = 2'd3; end
               4'd3: begin ma = f_ff[0]; mb = f_ff[2]; mx = 2'd3; end
               4'd4: begin ma = f_ff[0]; mb = f_ff[1]; mx = 2'd3; end
               default: ;
            endcase
         end else if (!quad) begin
            case (step_ff)
               4'd0: begin ma = f_ff[0]; mb = f_ff[1]; end
               4'd1: begin ma = mp; mb = f_ff[2]; end
               4'd2: begin ma = mp; mb = sum_ff; mx = 2'd3; end
               4'd3: begin ma = f_ff[1]; mb = f_ff[2]; end
               4'd4: begin ma = mp; mb = sum_ff + f_ff[0]; mx = 2'd3; end
               4'd5: begin ma = f_ff[0]; mb = f_ff[2]; end
               4'd6: begin ma = mp; mb = sum_ff + f_ff[1]; mx = 2'd3; end
               4'd7: begin ma = f_ff[0]; mb = f_ff[1]; end
               4'd8: begin ma = mp; mb = sum_ff + f_ff[2]; mx = 2'd3; end
               default: ;
            endcase
         end else begin
            case (step_ff)
               4'd0: begin ma = f_ff[0]; mb = f_ff[1]; end
               4'd1: begin ma = mp; mb = f_ff[2]; mx = 2'd2; end
               4'd2: begin ma = x_ff[q]; mb = f_ff[bq]; end
               4'd3: begin ma = mp; mb = f_ff[cq]; mx = 2'd1; end
               4'd4: begin ma = f_ff[q]; mb = f_ff[cq]; mx = 2'd2; end
               4'd5: begin ma = f_ff[q]; mb = f_ff[bq]; mx = 2'd2; end
               default: ;
            endcase
         end
      end
      last_step = step_ff == nsteps - 4'd1;
   end

   assign cap      = (st_ff == MUL && step_ff != 4'd0) || st_ff == WAIT;
   assign rstep    = (st_ff == WAIT) ? step_ff : step_ff - 4'd1;
   assign out_load = (st_ff == OUT) && (!ovalid_ff || o_ready);

   assign q_pop   = (st_ff == IDLE) && q_valid;
   assign o_valid = ovalid_ff;
   assign o_node  = onode_ff;
   assign o_vals  = vals_ff;
   assign o_last  = olast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         if (out_load) ovalid_ff <= 1'b1;
         else if (o_ready) ovalid_ff <= 1'b0;
         case (st_ff)
            IDLE: if (q_valid) begin
               pt_ff <= q_pt;
               x_ff[0] <= w_type'(q_pt.r);
               x_ff[1] <= w_type'(q_pt.s);
               x_ff[2] <= w_type'(q_pt.t);
               node_ff <= 5'd0;
               step_ff <= 4'd0;
               st_ff <= PREP;
            end
            PREP: begin
               // squares of the coordinates, one per cycle, for mid-edge nodes
               if (step_ff != 4'd0) sq_ff[step_ff[1:0] - 2'd1] <= mp;
               if (step_ff == 4'd3) st_ff <= LOAD;
               else step_ff <= step_ff + 4'd1;
            end
            LOAD: begin
               for (int i = 0; i < 3; i++) f_ff[i] <= fac[i];
               sum_ff <= fac[0] + fac[1] + fac[2] - FIVE;
               step_ff <= 4'd0;
               st_ff <= MUL;
            end
            MUL: begin
               if (last_step) st_ff <= WAIT;
               else step_ff <= step_ff + 4'd1;
            end
            WAIT: st_ff <= OUT;
            OUT: if (out_load) begin
               if (last_node) st_ff <= IDLE;
               else begin
                  node_ff <= node_ff + 5'd1;
                  st_ff <= LOAD;
               end
            end
            default: st_ff <= IDLE;
         endcase
         // value in res 0, derivatives by axis in res 1..3
         if (cap) begin
            if (pt_ff.kind == KIND_HEX8) begin
               case (rstep)
                  4'd1: res_ff[0] <= mp;
                  4'd2: res_ff[1] <= sgn(dir[1:0], mp);
                  4'd3: res_ff[2] <= sgn(dir[3:2], mp);
                  4'd4: res_ff[3] <= sgn(dir[5:4], mp);
                  default: ;
               endcase
            end else if (!quad) begin
               case (rstep)
                  4'd2: res_ff[0] <= mp;
                  4'd4: res_ff[1] <= sgn(dir[1:0], mp);
                  4'd6: res_ff[2] <= sgn(dir[3:2], mp);
                  4'd8: res_ff[3] <= sgn(dir[5:4], mp);
                  default: ;
               endcase
            end else begin
               case (rstep)
                  4'd1: res_ff[0] <= mp;
                  4'd3: res_ff[q + 2'd1] <= -mp;
                  4'd4: res_ff[bq + 2'd1] <= sgn(dir[2*bq +: 2], mp);
                  4'd5: res_ff[cq + 2'd1] <= sgn(dir[2*cq +: 2], mp);
                  default: ;
               endcase
            end
         end
         if (out_load) begin
            onode_ff <= node_ff;
            olast_ff <= last_node;
            vals_ff  <= {pt_ff.derivs ? sat(res_ff[3]) : OW'(0),
                         pt_ff.derivs ? sat(res_ff[2]) : OW'(0),
                         pt_ff.derivs ? sat(res_ff[1]) : OW'(0),
                         sat(res_ff[0])};
         end
      end
   end
endmodule

[hw/rtl/hex_shape_function_eval.sv]
// Hexahedral shape function evaluator, top level. Depends on hsfe_pkg,
// hsfe_front, hsfe_back and assert_macros.svh.
//
// Takes one natural point (r,s,t) in Q2.14 with an element kind (8-node or
// 20-node hexahedron) and a derivative flag, and streams one response per
// node: shape value and dN/dr, dN/ds, dN/dt in Q3.14, ties rounded away
// from zero, saturated to 17 bits, tlast on the final node. All products go
// through one shared rounding multiplier, one product per cycle. A point
// is first picked up and its coordinate squares formed; then each node takes
// a factor load, its products, the last product and an output step. A
// response that waits on rsp_tready holds the node sequencer. A two-entry
// request queue in front lets new requests be taken while a point is still
// being worked.
`include "assert_macros.svh"
module hex_shape_function_eval import hsfe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // coord_r, coord_s, coord_t
   input  logic [1:0]  req_tuser,  // element_kind, with_derivs
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,  // node_index, shape_value, deriv_r, deriv_s, deriv_t, 0
   output logic        rsp_tlast
);
   point_type in_pt, q_pt;
   logic q_valid, q_pop;
   logic [4:0] node;
   logic [4*OW-1:0] vals;

   assign in_pt = '{r: req_tdata[15:0], s: req_tdata[31:16], t: req_tdata[47:32],
                    kind: req_tuser[0], derivs: req_tuser[1]};

   hsfe_front u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready), .in_pt,
      .q_valid, .q_pop, .q_pt);

   hsfe_back u_back (
      .clock, .reset, .q_valid, .q_pop, .q_pt,
      .o_valid(rsp_tvalid), .o_ready(rsp_tready), .o_node(node), .o_vals(vals),
      .o_last(rsp_tlast));

   assign rsp_tdata = {7'b0, vals, node};

   `CHK_IMPL(a_last_node, clock, reset, rsp_tvalid && rsp_tlast,
             rsp_tdata[4:0] == 5'd7 || rsp_tdata[4:0] == 5'd19, "tlast on wrong node")
   `CHK_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
             rsp_tvalid && $stable(rsp_tdata), "response dropped while stalled")
endmodule

[tb/hsfe_scoreboard.sv]
// Scoreboard for the hexahedral shape function evaluator: predicts node responses.
// Depends on hsfe_pkg for the element kind codes.
`timescale 1ns / 1ps
class hsfe_scoreboard;
   typedef struct {
      logic [4:0]         node;
      logic signed [16:0] value;
      logic signed [16:0] dr;
      logic signed [16:0] ds;
      logic signed [16:0] dt;
      logic               last;
   } node_rsp_type;

   node_rsp_type expected_nodes[$];
   int        errors;
   int        node_sign[20][3];

   function new();
      node_sign = '{'{1,-1,-1}, '{1,1,-1}, '{-1,1,-1}, '{-1,-1,-1},
                    '{1,-1,1}, '{1,1,1}, '{-1,1,1}, '{-1,-1,1},
                    '{1,0,-1}, '{0,1,-1}, '{-1,0,-1}, '{0,-1,-1},
                    '{1,0,1}, '{0,1,1}, '{-1,0,1}, '{0,-1,1},
                    '{1,-1,0}, '{1,1,0}, '{-1,1,0}, '{-1,-1,0}};
      errors = 0;
   endfunction

   // rounded fixed-point product with extra right shift, ties away from zero
   function longint qmul(longint a, longint b, int extra);
      longint p, mag;
      p = a * b;
      mag = (p < 0) ? -p : p;
      mag = (mag + (longint'(1) << (13 + extra))) >>> (14 + extra);
      return (p < 0) ? -mag : mag;
   endfunction

   function logic signed [16:0] clip17(longint v);
      if (v > 65535) return 17'sd65535;
      if (v < -65536) return -17'sd65536;
      return v[16:0];
   endfunction

   function void note_point(logic signed [15:0] r, logic signed [15:0] s,
                            logic signed [15:0] t, logic kind, logic derivs);
      longint    one, x[3], f[3], val, d[3], sum;
      int        cnt, q, b, c, sg;
      node_rsp_type e;
      one = 16384;
      x[0] = r; x[1] = s; x[2] = t;
      cnt = (kind == hsfe_pkg::KIND_HEX20) ? 20 : 8;
      for (int n = 0; n < cnt; n++) begin
         q = -1;
         d = '{0, 0, 0};
         for (int a = 0; a < 3; a++) begin
            sg = node_sign[n][a];
            if (sg == 0) begin
               f[a] = one - qmul(x[a], x[a], 0);
               q = a;
            end else begin
               f[a] = (sg > 0) ? one + x[a] : one - x[a];
            end
         end
         if (kind == hsfe_pkg::KIND_HEX8) begin
            val = qmul(qmul(f[0], f[1], 0), f[2], 3);
            if (derivs)
               for (int a = 0; a < 3; a++) begin
                  b = (a == 0) ? 1 : 0;
                  c = (a == 2) ? 1 : 2;
                  d[a] = node_sign[n][a] * qmul(f[b], f[c], 3);
               end
         end else if (q < 0) begin
            // corner node: trilinear term times (A+B+C-5)
            sum = f[0] + f[1] + f[2] - 5 * one;
            val = qmul(qmul(qmul(f[0], f[1], 0), f[2], 0), sum, 3);
            if (derivs)
               for (int a = 0; a < 3; a++) begin
                  b = (a == 0) ? 1 : 0;
                  c = (a == 2) ? 1 : 2;
                  d[a] = node_sign[n][a] * qmul(qmul(f[b], f[c], 0), sum + f[a], 3);
               end
         end else begin
            // mid-edge node, quadratic along axis q
            b = (q == 0) ? 1 : 0;
            c = (q == 2) ? 1 : 2;
            val = qmul(qmul(f[0], f[1], 0), f[2], 2);
            if (derivs) begin
               d[q] = -qmul(qmul(x[q], f[b], 0), f[c], 1);
               d[b] = node_sign[n][b] * qmul(f[q], f[c], 2);
               d[c] = node_sign[n][c] * qmul(f[q], f[b], 2);
            end
         end
         e.node = 5'(n);
         e.value = clip17(val);
         e.dr = clip17(d[0]);
         e.ds = clip17(d[1]);
         e.dt = clip17(d[2]);
         e.last = (n == cnt - 1);
         expected_nodes.push_back(e);
      end
   endfunction

   function void check_node(logic [79:0] data, logic last);
      node_rsp_type e;
      if (expected_nodes.size() == 0) begin
         $error("response with no request pending: %h", data);
         errors++;
         return;
      end
      e = expected_nodes.pop_front();
      if (data[4:0] !== e.node) begin
         $error("node_index: expected %0d, got %0d", e.node, data[4:0]); errors++;
      end
      if (data[21:5] !== e.value) begin
         $error("shape_value: expected %0d, got %0d", e.value, $signed(data[21:5]));
         errors++;
      end
      if (data[38:22] !== e.dr) begin
         $error("deriv_r: expected %0d, got %0d", e.dr, $signed(data[38:22])); errors++;
      end
      if (data[55:39] !== e.ds) begin
         $error("deriv_s: expected %0d, got %0d", e.ds, $signed(data[55:39])); errors++;
      end
      if (data[72:56] !== e.dt) begin
         $error("deriv_t: expected %0d, got %0d", e.dt, $signed(data[72:56])); errors++;
      end
      if (last !== e.last) begin
         $error("last_node: expected %0d, got %0d", e.last, last); errors++;
      end
   endfunction
endclass

[tb/tb_hex_shape_function_eval.sv]
// Top testbench for hex_shape_function_eval: drives points, checks node responses.
// Depends on hsfe_pkg, hsfe_scoreboard and the RTL of the block.
`timescale 1ns / 1ps
module tb_hex_shape_function_eval;
   import hsfe_pkg::*;

   localparam int STALL_LIMIT = 5000;  // cycles with no handshake at all

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;  // coord_r, coord_s, coord_t
   logic [1:0]  req_tuser = '0;  // element_kind, with_derivs
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [79:0] rsp_tdata;       // node_index, shape_value, deriv_r, deriv_s, deriv_t, 0
   logic        rsp_tlast;

   hsfe_scoreboard node_sb = new();
   int send_idle_pct = 0;  // chance per cycle that the sender holds off
   int recv_stall_pct = 0; // chance per cycle that the receiver stalls
   int quiet_cycles = 0;

   hex_shape_function_eval DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // receiver: random backpressure, changed on the falling edge
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   // check each accepted response; watchdog on handshake silence
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         node_sb.check_node(rsp_tdata, rsp_tlast);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // one request; entered and left at a falling edge
   task automatic send_point(logic signed [15:0] r, logic signed [15:0] s,
                             logic signed [15:0] t, logic kind, logic derivs);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {t, s, r};
      req_tuser <= {derivs, kind};
      do @(posedge clock); while (!req_tready);
      node_sb.note_point(r, s, t, kind, derivs);
      @(negedge clock);
   endtask

   // mostly inside the element, sometimes the full 16-bit range
   function automatic logic signed [15:0] rand_coord();
      case ($urandom_range(9))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'sd0;
         3: return $signed(16'($urandom()));
         default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
      endcase
   endfunction

   task automatic drain();
      req_tvalid <= 0;
      while (node_sb.expected_nodes.size() != 0) @(negedge clock);
   endtask

   initial begin
      logic signed [15:0] edges[3];
      edges = '{-16'sd16384, 16'sd0, 16'sd16384};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: cube corners, center and interior points, both kinds, flag on and off
      foreach (edges[i])
         send_point(edges[i], edges[i], edges[i], KIND_HEX20, 1'b1);
      send_point(-16'sd16384, 16'sd16384, -16'sd16384, KIND_HEX8, 1'b1);
      send_point(16'sd16384, -16'sd16384, 16'sd16384, KIND_HEX8, 1'b1);
      send_point(16'sd0, 16'sd0, 16'sd0, KIND_HEX8, 1'b1);
      send_point(16'sd16384, 16'sd16384, 16'sd16384, KIND_HEX8, 1'b0);
      send_point(-16'sd16384, -16'sd16384, -16'sd16384, KIND_HEX20, 1'b0);
      send_point(16'sd8192, -16'sd8191, 16'sd1, KIND_HEX20, 1'b1);
      send_point(-16'sd1, 16'sd12345, -16'sd16383, KIND_HEX8, 1'b1);
      send_point(16'sd16383, 16'sd0, -16'sd8192, KIND_HEX20, 1'b0);

      // hold off until the block has emptied
      drain();

      // random phases: none, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 80 : (ph == 3) ? 36 : 0;
         recv_stall_pct = (ph == 2) ? 80 : (ph == 3) ? 36 : 0;
         for (int k = 0; k < 100; k++)
            send_point(rand_coord(), rand_coord(), rand_coord(),
                       1'($urandom_range(1)), $urandom_range(3) != 0);
      end
      drain();
      repeat (300) @(posedge clock);
      if (node_sb.errors == 0 && node_sb.expected_nodes.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
